@@ rtl/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared widths, defaults and the command/status bundles that pass between
// the controller and the datapath of the sample standard deviation block.
// ----------------------------------------------------------------------------
package ssd_pkg;

	// Fixed field widths of the ports.
	localparam int SAMPLE_W = 24;
	localparam int DEV_W = 25;
	localparam int COUNT_W = 11;

	// Default buffer capacity in samples.
	localparam int MAX_SAMPLES_DEF = 1024;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store;      // accepted sample beat: store it and update the sum, or flag a drop when full
		logic div_start;  // start the shared divider
		logic div_var;    // 0: sum / count, 1: squares / (count - 1)
		logic mean_load;  // capture the signed mean and restart the walk
		logic walk_rd;    // read the next stored sample
		logic sqrt_start; // start the square root on the divider quotient
		logic out_load;   // load the result register and close the segment
	} ssd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic first;      // no sample held yet in this segment
		logic div_busy;
		logic walk_last;  // the current read is the last held sample
		logic pipe_busy;  // squares still in flight
		logic sqrt_busy;
		logic out_free;   // result register may be loaded this cycle
	} ssd_status_t;

endpackage

@@ rtl/ssd_div.sv @@
// ----------------------------------------------------------------------------
// ssd_div
// Restoring unsigned divider, one quotient bit per cycle. The quotient is
// valid whenever busy is low after a start.
// ----------------------------------------------------------------------------
module ssd_div #(
	parameter int DIVIDEND_W = 58,
	parameter int DIVISOR_W = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic [STEP_W-1:0]     step_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVISOR_W:0]    shifted;
	logic                  take;
	logic [DIVISOR_W:0]    diff;

	// One trial subtraction per cycle.
	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign take = (shifted >= {1'b0, dsr_q});
	assign diff = shifted - {1'b0, dsr_q};

	// Control: step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DIVIDEND_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: the dividend shifts out as the quotient shifts in.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], take};
			rem_q <= take ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;

endmodule

@@ rtl/ssd_sqrt.sv @@
// ----------------------------------------------------------------------------
// ssd_sqrt
// Digit-by-digit floor square root, one root bit per cycle. The root is
// valid whenever busy is low after a start.
// ----------------------------------------------------------------------------
module ssd_sqrt #(
	parameter int IN_W = 58
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [IN_W-1:0]   radicand,
	output logic              busy,
	output logic [IN_W/2-1:0] root
);

	localparam int ROOT_W = IN_W / 2;
	localparam int STEP_W = $clog2(ROOT_W + 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [IN_W-1:0]   val_q;
	logic [ROOT_W:0]   rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W+2:0] rem_sh;
	logic [ROOT_W+2:0] trial;
	logic              take;
	logic [ROOT_W+2:0] diff;

	// Bring down two bits and try the next root bit.
	assign rem_sh = {rem_q, val_q[IN_W-1:IN_W-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign take = (rem_sh >= trial);
	assign diff = rem_sh - trial;

	// Control: step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(ROOT_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: remainder, partial root and the radicand bits still to use.
	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[IN_W-3:0], 2'b00};
			rem_q <= take ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

@@ rtl/ssd_datapath.sv @@
// ----------------------------------------------------------------------------
// ssd_datapath
// Sample buffer, running sum, squared deviation pipeline, shared divider,
// square root and the result register.
// ----------------------------------------------------------------------------
module ssd_datapath #(
	parameter int MAX_SAMPLES = ssd_pkg::MAX_SAMPLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ssd_pkg::ssd_cmd_t                   cmd,
	output ssd_pkg::ssd_status_t                status,
	input  logic signed [ssd_pkg::SAMPLE_W-1:0] sample,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [ssd_pkg::DEV_W-1:0]    deviation,
	output logic [ssd_pkg::COUNT_W-1:0]         sample_count,
	output logic                                overflow
);

	import ssd_pkg::*;

	localparam int IDX_W = $clog2(MAX_SAMPLES);
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = SAMPLE_W + IDX_W + 1;
	localparam int ACC_W = 2 * SAMPLE_W + IDX_W;
	localparam int SQ_W = 2 * ((ACC_W + 1) / 2);
	localparam int ROOT_W = SQ_W / 2;
	localparam int MEAN_W = SAMPLE_W + 1;
	localparam int DIFF_W = SAMPLE_W + 2;
	localparam int MAG_W = SAMPLE_W + 1;

	// Segment state.
	logic [CNT_W-1:0]           cnt_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic                       drop_q;
	logic signed [SAMPLE_W-1:0] first_q;
	logic                       full;
	logic                       wr_en;

	// Sample buffer.
	logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];

	// Walk and squares pipeline.
	logic [IDX_W-1:0]          idx_q;
	logic signed [MEAN_W-1:0]  mean_q;
	logic signed [SAMPLE_W-1:0] rd_s1;
	logic                      rd_vld_s1;
	logic [2*MAG_W-1:0]        prod_s2;
	logic                      prod_vld_s2;
	logic [ACC_W-1:0]          acc_q;
	logic signed [DIFF_W-1:0]  diff;
	logic [DIFF_W-1:0]         diff_mag;
	logic [MAG_W-1:0]          mag;

	// Divider and square root.
	logic                 sum_neg;
	logic [SUM_W-1:0]     sum_mag;
	logic [ACC_W-1:0]     div_dividend;
	logic [CNT_W-1:0]     div_divisor;
	logic                 div_busy;
	logic [ACC_W-1:0]     div_quo;
	logic [MEAN_W-1:0]    mean_mag;
	logic                 sqrt_busy;
	logic [ROOT_W-1:0]    root;

	// Result register.
	logic                    out_valid_q;
	logic signed [DEV_W-1:0] dev_q;
	logic [COUNT_W-1:0]      count_q;
	logic                    ovf_q;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;
	logic                    out_free;

	assign full = (cnt_q == CNT_W'(MAX_SAMPLES));
	assign wr_en = cmd.store && !full;

	// Count, running sum and the dropped flag of the open segment.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			drop_q <= 1'b0;
		end else if (cmd.out_load) begin
			cnt_q <= '0;
			sum_q <= '0;
			drop_q <= 1'b0;
		end else if (cmd.store) begin
			if (full) begin
				drop_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
				sum_q <= sum_q + SUM_W'(sample);
			end
		end
	end

	// The first sample is kept apart for the one-sample segment.
	always_ff @(posedge clk) begin
		if (wr_en && (cnt_q == '0)) begin
			first_q <= sample;
		end
	end

	// Buffer write on each stored beat; registered read during the walk.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[IDX_W-1:0]] <= sample;
		end
		if (cmd.walk_rd) begin
			rd_s1 <= mem[idx_q];
		end
	end

	// Shared divider operands.
	assign sum_neg = sum_q[SUM_W-1];
	assign sum_mag = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign div_dividend = cmd.div_var ? acc_q : ACC_W'(sum_mag);
	assign div_divisor = cmd.div_var ? (cnt_q - CNT_W'(1)) : cnt_q;

	ssd_div #(
		.DIVIDEND_W (ACC_W),
		.DIVISOR_W  (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// The mean magnitude fits the sample range; truncation is toward zero.
	assign mean_mag = {1'b0, div_quo[SAMPLE_W-1:0]};

	always_ff @(posedge clk) begin
		if (cmd.mean_load) begin
			mean_q <= sum_neg ? -$signed(mean_mag) : $signed(mean_mag);
		end
	end

	// Walk address and pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			rd_vld_s1 <= 1'b0;
			prod_vld_s2 <= 1'b0;
		end else begin
			if (cmd.mean_load) begin
				idx_q <= '0;
			end else if (cmd.walk_rd) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			rd_vld_s1 <= cmd.walk_rd;
			prod_vld_s2 <= rd_vld_s1;
		end
	end

	// Deviation from the mean, its magnitude and square.
	assign diff = DIFF_W'(rd_s1) - DIFF_W'(mean_q);
	assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign mag = diff_mag[MAG_W-1:0];

	always_ff @(posedge clk) begin
		prod_s2 <= mag * mag;
		if (cmd.mean_load) begin
			acc_q <= '0;
		end else if (prod_vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	ssd_sqrt #(
		.IN_W (SQ_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (SQ_W'(div_quo)),
		.busy     (sqrt_busy),
		.root     (root)
	);

	// Result register; it parts the computation from the output handshake.
	assign out_free = !out_valid_q || out_ready;
	assign cnt_ext = {COUNT_W'(0), cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			dev_q <= (cnt_q == CNT_W'(1)) ? DEV_W'(first_q) : $signed(root[DEV_W-1:0]);
			count_q <= cnt_ext[COUNT_W-1:0];
			ovf_q <= drop_q;
		end
	end

	// Status back to the controller.
	always_comb begin
		status.first = (cnt_q == '0);
		status.div_busy = div_busy;
		status.walk_last = (CNT_W'(idx_q) == (cnt_q - CNT_W'(1)));
		status.pipe_busy = rd_vld_s1 || prod_vld_s2;
		status.sqrt_busy = sqrt_busy;
		status.out_free = out_free;
	end

	assign out_valid = out_valid_q;
	assign deviation = dev_q;
	assign sample_count = count_q;
	assign overflow = ovf_q;

endmodule

@@ rtl/ssd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssd_ctrl
// Sequencer: loads samples, then runs mean, squares walk, variance divide
// and square root for each closed segment of more than one sample, and hands off the result.
// ----------------------------------------------------------------------------
module ssd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 last,
	output logic                 in_ready,
	input  ssd_pkg::ssd_status_t status,
	output ssd_pkg::ssd_cmd_t    cmd
);

	import ssd_pkg::*;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_MEAN_GO   = 4'd1;
	localparam logic [3:0] ST_MEAN_WAIT = 4'd2;
	localparam logic [3:0] ST_WALK      = 4'd3;
	localparam logic [3:0] ST_DRAIN     = 4'd4;
	localparam logic [3:0] ST_VAR_GO    = 4'd5;
	localparam logic [3:0] ST_VAR_WAIT  = 4'd6;
	localparam logic [3:0] ST_ROOT_WAIT = 4'd7;
	localparam logic [3:0] ST_DONE      = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.store = accept;
				if (accept && last) begin
					state_d = status.first ? ST_DONE : ST_MEAN_GO;
				end
			end
			ST_MEAN_GO: begin
				cmd.div_start = 1'b1;
				state_d = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT: begin
				if (!status.div_busy) begin
					cmd.mean_load = 1'b1;
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk_rd = 1'b1;
				if (status.walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = ST_VAR_GO;
				end
			end
			ST_VAR_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_var = 1'b1;
				state_d = ST_VAR_WAIT;
			end
			ST_VAR_WAIT: begin
				if (!status.div_busy) begin
					cmd.sqrt_start = 1'b1;
					state_d = ST_ROOT_WAIT;
				end
			end
			ST_ROOT_WAIT: begin
				if (!status.sqrt_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/sample_std_deviation.sv @@
// ----------------------------------------------------------------------------
// sample_std_deviation: takes one sample beat per cycle while a segment loads.
// Once a segment closes, out_valid rises after two 58-step divides, the walk over the
// N held samples and a 29-step root (step counts at the default capacity); a lone
// sample skips all of these. in_ready stays low until the result is loaded.
// ----------------------------------------------------------------------------
module sample_std_deviation #(
	parameter int MAX_SAMPLES = ssd_pkg::MAX_SAMPLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [ssd_pkg::SAMPLE_W-1:0] sample,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [ssd_pkg::DEV_W-1:0]    deviation,
	output logic [ssd_pkg::COUNT_W-1:0]         sample_count,
	output logic                                overflow
);

	import ssd_pkg::*;

	ssd_cmd_t    cmd;
	ssd_status_t status;

	// Sequencer.
	ssd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Storage and arithmetic.
	ssd_datapath #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample       (sample),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.deviation    (deviation),
		.sample_count (sample_count),
		.overflow     (overflow)
	);

endmodule
